// ===== hw/rtl/pn2d_pkg.sv =====
// ---------------------------------------------------------------------------
// pn2d_pkg
// Shared constants and arithmetic helpers for the 2-D gradient noise block.
// ---------------------------------------------------------------------------
package pn2d_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PERIOD      = 256;
    localparam int TABLE_DEPTH = 512;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    // Item kinds carried on the input channel.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Ten in Q.16, the constant term of the fade polynomial.
    localparam logic [19:0] TEN_ONE = 20'd655360;

    // Diagonal gradient chosen by the low two bits of a corner hash.
    localparam logic [1:0] GRAD_PP = 2'd0;
    localparam logic [1:0] GRAD_NP = 2'd1;
    localparam logic [1:0] GRAD_PN = 2'd2;

    typedef logic signed [19:0] sval_t;
    typedef logic [16:0]        weight_t;

    function automatic sval_t grad(input logic [1:0] h,
                                   input logic signed [16:0] dx,
                                   input logic signed [16:0] dy);
        sval_t ex;
        sval_t ey;
        ex = 20'(dx);
        ey = 20'(dy);
        case (h)
            GRAD_PP: grad = ex + ey;
            GRAD_NP: grad = ey - ex;
            GRAD_PN: grad = ex - ey;
            default: grad = -ex - ey;
        endcase
    endfunction

    // a + floor(w * (b - a) / 2^16)
    function automatic sval_t lerp(input sval_t a, input sval_t b, input weight_t w);
        logic signed [20:0] d;
        logic signed [38:0] p;
        d = 21'(b) - 21'(a);
        p = 39'($signed({1'b0, w})) * 39'(d);
        lerp = a + p[35:16];
    endfunction

endpackage

// ===== hw/rtl/perlin_noise_2d.sv =====
// ---------------------------------------------------------------------------
// perlin_noise_2d
// Two-dimensional gradient noise with a loadable permutation table.
// ---------------------------------------------------------------------------
// A load transfer (kind 0) writes one byte of the 512-entry permutation table
// and produces no result; a load is taken in any cycle the output is not
// stalled. A sample transfer (kind 1) carries unsigned 16.16 coordinates and
// its Q0.16 noise value passes through the stage registers and the output
// register before it is offered. The table is held in two identical copies,
// each with two read ports. When a sample is taken, the first copy looks up
// the two cell columns; while it is in stage 1, the same two ports of the
// first copy and both ports of the second copy perform the four chained
// corner lookups. Because the first copy serves both steps, no sample is
// taken while another is in stage 1, but a load may be taken then. Table
// entries must be loaded before a sample reads them; there is no clearing
// pass after reset. A stalled output holds the whole pipeline, and the
// output register keeps its result until the downstream side takes it.
module perlin_noise_2d
    import pn2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [8:0]  table_index,
    input  logic [7:0]  table_value,
    input  logic [31:0] x_coord,
    input  logic [31:0] y_coord,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] noise_value
);

    logic [7:0] mem_a [TABLE_DEPTH];
    logic [7:0] mem_b [TABLE_DEPTH];

    logic        out_valid_reg;
    logic [15:0] noise_reg;
    logic        en;
    logic        take;
    logic        take_sample;
    logic        take_load;

    // Pipeline valid bits.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    // Stage 1: first lookup issued, first fade product.
    logic [15:0] xf1_reg, yf1_reg, tx2_1_reg, ty2_1_reg;
    logic [7:0]  cy1_reg, cyn1_reg;
    // Read data of the first copy: the column lookups after a sample is taken,
    // the aa and ab corner hashes after its stage-1 lookup.
    logic [7:0]  ra0_reg, ra1_reg;

    // Stage 2: corner hashes, second fade product.
    logic [15:0] xf2_reg, yf2_reg, tx3_reg, ty3_reg;
    logic [19:0] px_reg, py_reg;
    logic [7:0]  hba_reg, hbb_reg;

    // Stage 3: gradients and fade weights.
    sval_t   g00_reg, g10_reg, g01_reg, g11_reg;
    weight_t u3_reg, v3_reg;

    // Stage 4: first interpolations.
    sval_t   x1_reg, x2_reg;
    weight_t v4_reg;

    logic [7:0]  cx, cxn, cy, cyn;
    logic [15:0] xf, yf;
    logic [TABLE_AW-1:0] ad_aa, ad_ab, ad_ba, ad_bb;
    logic [TABLE_AW-1:0] rd_a0, rd_a1;
    logic [35:0] fx_prod, fy_prod;
    weight_t     fx, fy;
    logic signed [16:0] dx0, dx1, dy0, dy1;
    sval_t       r;
    logic signed [20:0] s;
    logic [15:0] noise_next;

    assign en          = !out_valid_reg || out_ready;
    // A sample cannot enter while the previous one uses the second lookup.
    assign in_ready    = en && !(s1_valid_reg && (kind == KIND_SAMPLE));
    assign take        = in_valid && in_ready;
    assign take_sample = take && (kind == KIND_SAMPLE);
    assign take_load   = take && (kind == KIND_LOAD);

    assign xf  = x_coord[FRAC_BITS-1:0];
    assign yf  = y_coord[FRAC_BITS-1:0];
    assign cx  = x_coord[FRAC_BITS +: 8];
    assign cy  = y_coord[FRAC_BITS +: 8];
    assign cxn = cx + 8'd1;
    assign cyn = cy + 8'd1;

    assign ad_aa = {1'b0, ra0_reg} + {1'b0, cy1_reg};
    assign ad_ab = {1'b0, ra0_reg} + {1'b0, cyn1_reg};
    assign ad_ba = {1'b0, ra1_reg} + {1'b0, cy1_reg};
    assign ad_bb = {1'b0, ra1_reg} + {1'b0, cyn1_reg};

    // The first copy serves the column lookups unless a sample is in
    // stage 1, when it serves the aa and ab corners.
    assign rd_a0 = s1_valid_reg ? ad_aa : {1'b0, cx};
    assign rd_a1 = s1_valid_reg ? ad_ab : {1'b0, cxn};

    // Table copies: reads see the contents before a same-cycle load.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra0_reg <= mem_a[rd_a0];
            ra1_reg <= mem_a[rd_a1];
            hba_reg <= mem_b[ad_ba];
            hbb_reg <= mem_b[ad_bb];
        end
        if (take_load)
        begin
            mem_a[table_index] <= table_value;
            mem_b[table_index] <= table_value;
        end
    end

    assign fx_prod = 36'(tx3_reg) * 36'(px_reg);
    assign fy_prod = 36'(ty3_reg) * 36'(py_reg);
    assign fx = (fx_prod[35:16] > 20'd65536) ? 17'd65536 : fx_prod[32:16];
    assign fy = (fy_prod[35:16] > 20'd65536) ? 17'd65536 : fy_prod[32:16];

    // Offsets to the near and far corners; xf - 1.0 is xf with a sign bit.
    assign dx0 = {1'b0, xf2_reg};
    assign dx1 = {1'b1, xf2_reg};
    assign dy0 = {1'b0, yf2_reg};
    assign dy1 = {1'b1, yf2_reg};

    assign r = lerp(x1_reg, x2_reg, v4_reg);
    assign s = 21'(r) + 21'sd65536;

    always_comb
    begin
        if (s <= 21'sd0)
            noise_next = 16'd0;
        else if (s[20:1] > 20'd65535)
            noise_next = 16'hFFFF;
        else
            noise_next = s[16:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xf1_reg   <= xf;
            yf1_reg   <= yf;
            cy1_reg   <= cy;
            cyn1_reg  <= cyn;
            tx2_1_reg <= 16'((32'(xf) * 32'(xf)) >> FRAC_BITS);
            ty2_1_reg <= 16'((32'(yf) * 32'(yf)) >> FRAC_BITS);

            xf2_reg <= xf1_reg;
            yf2_reg <= yf1_reg;
            tx3_reg <= 16'((32'(tx2_1_reg) * 32'(xf1_reg)) >> FRAC_BITS);
            ty3_reg <= 16'((32'(ty2_1_reg) * 32'(yf1_reg)) >> FRAC_BITS);
            px_reg  <= 20'(3'd6 * 20'(tx2_1_reg)) + TEN_ONE - 20'(4'd15 * 20'(xf1_reg));
            py_reg  <= 20'(3'd6 * 20'(ty2_1_reg)) + TEN_ONE - 20'(4'd15 * 20'(yf1_reg));

            g00_reg <= grad(ra0_reg[1:0], dx0, dy0);
            g10_reg <= grad(hba_reg[1:0], dx1, dy0);
            g01_reg <= grad(ra1_reg[1:0], dx0, dy1);
            g11_reg <= grad(hbb_reg[1:0], dx1, dy1);
            u3_reg  <= fx;
            v3_reg  <= fy;

            x1_reg <= lerp(g00_reg, g10_reg, u3_reg);
            x2_reg <= lerp(g01_reg, g11_reg, u3_reg);
            v4_reg <= v3_reg;

            noise_reg <= noise_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= take_sample;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

endmodule

// ===== hw/rtl/pn2d_checker.sv =====
// ---------------------------------------------------------------------------
// pn2d_checker
// Port-level checks for the gradient noise block, bound to its top level.
// ---------------------------------------------------------------------------
module pn2d_checker
    import pn2d_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] noise_value
);

    // A result waiting for the downstream side stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Its value does not change while it waits.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(noise_value))
        else $error("result changed while stalled");

    // A sample transfer is never followed directly by another sample transfer.
    a_sample_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_SAMPLE)
        |=> !(in_valid && in_ready && (kind == KIND_SAMPLE)))
        else $error("two sample transfers in adjacent cycles");

    // A result never appears right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered straight out of reset");

endmodule

bind perlin_noise_2d pn2d_checker u_pn2d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .noise_value(noise_value)
);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for perlin_noise_2d: fills the permutation table, runs
// directed and random sample/load traffic under varying back-pressure, and
// compares every noise value against a fixed-point predictor of its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pn2d_pkg::*;

    localparam int   CYCLE_LIMIT = 400000;
    localparam int   DRAIN_CYCLES = 20;

    // Scoreboard: keeps a shadow copy of the permutation table and a queue of
    // noise values still owed by the block.
    class noise_scoreboard;
        logic [7:0]  perm [TABLE_DEPTH];
        logic [15:0] owed_noise [$];
        int          errors;
        int          samples_seen;

        function longint fade(longint t);
            longint one;
            longint t2;
            longint t3;
            longint p;
            longint f;
            one = longint'(1) << FRAC_BITS;
            t2 = (t * t) >>> FRAC_BITS;
            t3 = (t2 * t) >>> FRAC_BITS;
            p = 6 * t2 + 10 * one - 15 * t;
            f = (t3 * p) >>> FRAC_BITS;
            return (f > one) ? one : f;
        endfunction

        // Arithmetic shift on a signed longint floors toward minus infinity.
        function longint blend(longint a, longint b, longint w);
            return a + ((w * (b - a)) >>> FRAC_BITS);
        endfunction

        function longint corner(logic [7:0] h, longint dx, longint dy);
            case (h[1:0])
                GRAD_PP: return dx + dy;
                GRAD_NP: return dy - dx;
                GRAD_PN: return dx - dy;
                default: return -dx - dy;
            endcase
        endfunction

        function logic [7:0] hash2(int a, int b);
            return perm[(int'(perm[a % TABLE_DEPTH]) + b) % TABLE_DEPTH];
        endfunction

        function logic [15:0] noise_of(logic [31:0] xc, logic [31:0] yc);
            longint one;
            int cx;
            int cy;
            int cx1;
            int cy1;
            longint xf;
            longint yf;
            longint u;
            longint v;
            longint x1;
            longint x2;
            longint s;
            one = longint'(1) << FRAC_BITS;
            cx = (xc >> FRAC_BITS) % PERIOD;
            cy = (yc >> FRAC_BITS) % PERIOD;
            cx1 = (cx + 1) % PERIOD;
            cy1 = (cy + 1) % PERIOD;
            xf = xc & 32'h0000_FFFF;
            yf = yc & 32'h0000_FFFF;
            u = fade(xf);
            v = fade(yf);
            x1 = blend(corner(hash2(cx, cy), xf, yf),
                       corner(hash2(cx1, cy), xf - one, yf), u);
            x2 = blend(corner(hash2(cx, cy1), xf, yf - one),
                       corner(hash2(cx1, cy1), xf - one, yf - one), u);
            s = blend(x1, x2, v) + one;
            if (s <= 0)
                return 16'd0;
            s = s >>> (FRAC_BITS + 1 - 16);
            return (s > 65535) ? 16'hFFFF : 16'(s);
        endfunction

        function void note_input(logic k, logic [8:0] idx, logic [7:0] val,
                                 logic [31:0] xc, logic [31:0] yc);
            if (k == KIND_LOAD)
                perm[idx] = val;
            else
                owed_noise.push_back(noise_of(xc, yc));
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [15:0] got);
            logic [15:0] want;
            samples_seen++;
            if (owed_noise.size() == 0)
            begin
                report($sformatf("unexpected noise_value %0h", got));
                return;
            end
            want = owed_noise.pop_front();
            if (got !== want)
                report($sformatf("noise_value %0h, predicted %0h", got, want));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [8:0]  table_index;
    logic [7:0]  table_value;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] noise_value;

    noise_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycles;
    int  n_loads;
    int  n_samples;

    perlin_noise_2d DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .table_index(table_index), .table_value(table_value),
        .x_coord(x_coord), .y_coord(y_coord),
        .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Both transfer sides are observed with the values seen just before the
    // edge, so ordering inside the time step does not matter.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(kind, table_index, table_value, x_coord, y_coord);
        if (rst_n && out_valid && out_ready)
            sb.check_result(noise_value);
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one item, leaving valid high afterwards so a back-to-back
    // transfer never lowers and raises valid in the same time step. A sender
    // gap drops valid first.
    task automatic put_item(logic k, logic [8:0] idx, logic [7:0] val,
                            logic [31:0] xc, logic [31:0] yc);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        table_index <= idx;
        table_value <= val;
        x_coord     <= xc;
        y_coord     <= yc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == KIND_LOAD)
            n_loads++;
        else
            n_samples++;
    endtask

    task automatic load_entry(logic [8:0] idx, logic [7:0] val);
        put_item(KIND_LOAD, idx, val, $urandom, $urandom);
    endtask

    task automatic sample_at(logic [31:0] xc, logic [31:0] yc);
        put_item(KIND_SAMPLE, 9'($urandom), 8'($urandom), xc, yc);
    endtask

    // Mostly samples over the full coordinate range, with table rewrites
    // mixed in so the hashes keep moving.
    task automatic random_traffic(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 20)
                load_entry(9'($urandom), 8'($urandom));
            else if ($urandom_range(3) == 0)
                sample_at({8'($urandom), 24'($urandom)} & 32'hFFFF_FFFF,
                          {16'($urandom_range(3)), 16'($urandom)});
            else
                sample_at($urandom, $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        n_loads = 0;
        n_samples = 0;
        send_idle_pct = 28;
        recv_idle_pct = 70;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_LOAD;
        table_index = '0;
        table_value = '0;
        x_coord     = '0;
        y_coord     = '0;
        out_ready   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole table before any sample, since unloaded entries
        // have no defined contents.
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(9'(i), 8'($urandom));

        // Directed: table extremes, then coordinate corners and edges.
        load_entry(9'd0, 8'd0);
        load_entry(9'd511, 8'hFF);
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sample_at(32'h0000_FFFF, 32'h0000_0000);
        sample_at(32'h0000_0000, 32'h0000_FFFF);
        sample_at(32'h00FF_0000, 32'h00FF_0000);
        sample_at(32'h00FF_FFFF, 32'h00FF_8000);
        sample_at(32'h0100_0000, 32'hFF00_0001);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0001_0000, 32'h0000_4000);
        sample_at(32'hAAAA_5555, 32'h5555_AAAA);
        sample_at(32'h0080_C000, 32'h0003_2000);
        sample_at(32'h0000_0001, 32'hFFFF_0000);

        random_traffic(60);
        send_idle_pct = 70;
        recv_idle_pct = 28;
        random_traffic(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(50);
        in_valid <= 1'b0;

        while (sb.owed_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d table loads and %0d samples, %0d results checked",
                 n_loads, n_samples, sb.samples_seen);
        $display("three back-pressure phases, %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.owed_noise.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
